@@ rtl/lasr_pkg.sv @@
// shared constants and types for the list append / search / remove block
// no dependencies; imported by list_append_search_remove, lasr_checker and list_append_search_remove_test
`default_nettype none

package lasr_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ST_W     = 2;

  // stream payload layout
  localparam int unsigned IN_FIELDS_W  = ELEM_W + IDX_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
  localparam int unsigned OUT_FIELDS_W = IDX_W + ELEM_W + CNT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_FIND   = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ_WAIT,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_e;

endpackage

`default_nettype wire

@@ rtl/lasr_ram.sv @@
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module lasr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/list_append_search_remove.sv @@
// list with append, indexed read, linear find and compacting remove
// uses lasr_pkg and one lasr_ram instance for the element store
//
// usage
//   requests arrive on the s_axis channel: tuser carries the operation
//   (append, read, find, remove), tdata the element word and the position.
//   every request gives exactly one result beat on m_axis: tuser carries
//   the status, tdata the found index, the element read and the count.
//   one request is worked on at a time; s_axis_tready is high only while
//   the sequencer is idle.
// steps, from the accepted request to the result beat
//   append          exec writes the store unless the list is full, then the result state
//   read            exec issues the read when in range, read wait takes the data,
//                   then the result state
//   find            scan from the start up to a hit, or up to the count on a miss,
//                   which ends at once when the start is at or past the count
//   remove          the find scan, then the shift of the entries past the hit index
//   the single read port of the element store paces the scan and the shift:
//   each touches one entry per cycle
// the result sits in an output register, so a new request is accepted while
// the previous result still waits; a stalled receiver holds the result and
// the sequencer waits in its result state until the register frees up.
// reset clears the count and all control state; the store itself is not
// cleared, since only entries below the count are ever read.
`default_nettype none

module list_append_search_remove (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request channel
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [lasr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // value, position, zero pad
  input  wire logic [lasr_pkg::OP_W-1:0]         s_axis_tuser,  // operation
  // result channel
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output      logic [lasr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // found_index, element, count, zero pad
  output      logic [lasr_pkg::ST_W-1:0]         m_axis_tuser   // status
);

  import lasr_pkg::*;

  // sequencer state and request registers
  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [ELEM_W-1:0]  val_q, val_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // walk pointer and the index of the read in flight
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   pidx_q, pidx_d;
  logic               pend_q, pend_d;

  // pending result
  status_e            res_st_q, res_st_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic [ELEM_W-1:0]  res_elem_q, res_elem_d;

  // output register
  logic               out_vld_q, out_vld_d;
  logic [ST_W-1:0]    out_st_q, out_st_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [ELEM_W-1:0]  out_elem_q, out_elem_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;

  // store port signals
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ELEM_W-1:0]  ram_wdata, ram_rdata;

  logic               hit;

  lasr_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_q, out_elem_q, out_idx_q};

  // read data of the previous cycle matches the searched word
  assign hit = pend_q && (ram_rdata == val_q);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    val_d      = val_q;
    pos_d      = pos_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pidx_d     = pidx_q;
    pend_d     = pend_q;
    res_st_d   = res_st_q;
    res_idx_d  = res_idx_q;
    res_elem_d = res_elem_q;
    out_st_d   = out_st_q;
    out_idx_d  = out_idx_q;
    out_elem_d = out_elem_q;
    out_cnt_d  = out_cnt_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    ram_we     = 1'b0;
    ram_waddr  = count_q[IDX_W-1:0];
    ram_wdata  = val_q;
    ram_re     = 1'b0;
    ram_raddr  = idx_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = op_e'(s_axis_tuser);
          val_d   = s_axis_tdata[ELEM_W-1:0];
          pos_d   = s_axis_tdata[ELEM_W +: IDX_W];
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_st_d   = ST_OK;
        res_idx_d  = '0;
        res_elem_d = '0;
        unique case (op_q)
          OP_APPEND: begin
            if (count_q >= CNT_W'(CAPACITY)) begin
              res_st_d = ST_FULL;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
            state_d = S_RESULT;
          end
          OP_READ: begin
            res_idx_d = pos_q;
            if ({1'b0, pos_q} < count_q) begin
              ram_re    = 1'b1;
              ram_raddr = pos_q;
              state_d   = S_READ_WAIT;
            end else begin
              res_st_d = ST_RANGE;
              state_d  = S_RESULT;
            end
          end
          OP_FIND, OP_REMOVE: begin
            idx_d   = {1'b0, pos_q};
            pend_d  = 1'b0;
            state_d = S_SCAN;
          end
          default: state_d = S_RESULT;
        endcase
      end

      S_READ_WAIT: begin
        res_elem_d = ram_rdata;
        state_d    = S_RESULT;
      end

      // one entry read per cycle; the registered read data is compared with the searched word
      S_SCAN: begin
        if (hit) begin
          res_idx_d = pidx_q;
          if (op_q == OP_REMOVE) begin
            idx_d   = {1'b0, pidx_q} + CNT_W'(1);
            pend_d  = 1'b0;
            state_d = S_SHIFT;
          end else begin
            state_d = S_RESULT;
          end
        end else if (idx_q < count_q) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q[IDX_W-1:0];
          idx_d  = idx_q + CNT_W'(1);
        end else begin
          res_st_d = ST_NOT_FOUND;
          state_d  = S_RESULT;
        end
      end

      // read entry i+1, write it to entry i in the next cycle
      S_SHIFT: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q;
          ram_wdata = ram_rdata;
        end
        if (idx_q < count_q) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = IDX_W'(idx_q - CNT_W'(1));
          idx_d  = idx_q + CNT_W'(1);
        end else begin
          pend_d  = 1'b0;
          count_d = count_q - CNT_W'(1);
          state_d = S_RESULT;
        end
      end

      S_RESULT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_st_d   = res_st_q;
          out_idx_d  = res_idx_q;
          out_elem_d = res_elem_q;
          out_cnt_d  = count_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    val_q      <= val_d;
    pos_q      <= pos_d;
    idx_q      <= idx_d;
    pidx_q     <= pidx_d;
    res_st_q   <= res_st_d;
    res_idx_q  <= res_idx_d;
    res_elem_q <= res_elem_d;
    out_st_q   <= out_st_d;
    out_idx_q  <= out_idx_d;
    out_elem_q <= out_elem_d;
    out_cnt_q  <= out_cnt_d;
  end

endmodule

`default_nettype wire

@@ rtl/lasr_checker.sv @@
// port-level checks for list_append_search_remove, attached by bind
// uses lasr_pkg
`default_nettype none

module lasr_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [lasr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire logic [lasr_pkg::ST_W-1:0]         m_axis_tuser
);

  import lasr_pkg::*;

  logic [IDX_W-1:0]  res_idx;
  logic [ELEM_W-1:0] res_elem;
  logic [CNT_W-1:0]  res_cnt;

  assign res_idx  = m_axis_tdata[IDX_W-1:0];
  assign res_elem = m_axis_tdata[IDX_W +: ELEM_W];
  assign res_cnt  = m_axis_tdata[IDX_W + ELEM_W +: CNT_W];

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // one request at a time: ready drops after an accepted beat
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one still in work");

  // a full status only when the count is at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> res_cnt == CNT_W'(CAPACITY))
    else $error("full status below capacity");

  // not found carries zero index and element
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND) |-> res_idx == '0 && res_elem == '0)
    else $error("not found result with non-zero fields");

  // count never past capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_cnt <= CNT_W'(CAPACITY))
    else $error("count past capacity");

endmodule

bind list_append_search_remove lasr_checker u_lasr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ dv/list_append_search_remove_test.sv @@
// self-checking stream testbench for the list append / search / remove block
// depends on lasr_pkg and list_append_search_remove; a shadow list class predicts every result
`timescale 1ns / 100ps

// shadow copy of the list: predicts each result beat when a request is accepted
// and compares the result beats as they come back
class list_mirror;
  typedef struct {
    lasr_pkg::status_e               status;
    logic [lasr_pkg::IDX_W-1:0]      idx;
    logic [lasr_pkg::ELEM_W-1:0]     elem;
    logic [lasr_pkg::CNT_W-1:0]      count;
  } result_t;

  logic [lasr_pkg::ELEM_W-1:0] store [lasr_pkg::CAPACITY];
  int unsigned                 cnt;
  result_t                     due[$];
  int unsigned                 errors;

  function new();
    cnt    = 0;
    errors = 0;
  endfunction

  function void note_request(lasr_pkg::op_e op, logic [lasr_pkg::ELEM_W-1:0] v,
                             logic [lasr_pkg::IDX_W-1:0] pos);
    result_t r;
    int      hit;
    r.status = lasr_pkg::ST_OK;
    r.idx    = '0;
    r.elem   = '0;
    hit      = -1;
    case (op)
      lasr_pkg::OP_APPEND: begin
        if (cnt >= lasr_pkg::CAPACITY) begin
          r.status = lasr_pkg::ST_FULL;
        end else begin
          store[cnt] = v;
          cnt++;
        end
      end
      lasr_pkg::OP_READ: begin
        r.idx = pos;
        if (pos < cnt) r.elem = store[pos];
        else r.status = lasr_pkg::ST_RANGE;
      end
      default: begin
        // find and remove share the search from the start position
        for (int i = pos; i < cnt; i++) begin
          if (store[i] == v) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          r.status = lasr_pkg::ST_NOT_FOUND;
        end else begin
          r.idx = lasr_pkg::IDX_W'(hit);
          if (op == lasr_pkg::OP_REMOVE) begin
            cnt--;
            for (int i = hit; i < cnt; i++) store[i] = store[i+1];
          end
        end
      end
    endcase
    r.count = lasr_pkg::CNT_W'(cnt);
    due.push_back(r);
  endfunction

  function void check_result(logic [lasr_pkg::ST_W-1:0] status, logic [lasr_pkg::IDX_W-1:0] idx,
                             logic [lasr_pkg::ELEM_W-1:0] elem,
                             logic [lasr_pkg::CNT_W-1:0] count);
    result_t want;
    if (due.size() == 0) begin
      $display("%0t: result beat with nothing expected: status %0d index %0d element %h count %0d",
               $time, status, idx, elem, count);
      errors++;
      return;
    end
    want = due.pop_front();
    if (want.status !== status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, status);
      errors++;
    end
    if (want.idx !== idx) begin
      $display("%0t: found_index mismatch, expected %0d, actual %0d", $time, want.idx, idx);
      errors++;
    end
    if (want.elem !== elem) begin
      $display("%0t: element mismatch, expected %h, actual %h", $time, want.elem, elem);
      errors++;
    end
    if (want.count !== count) begin
      $display("%0t: count mismatch, expected %0d, actual %0d", $time, want.count, count);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return due.size();
  endfunction
endclass

module list_append_search_remove_test;
  import lasr_pkg::*;

  // a full-list remove walks the store about once, so the quiet
  // limit sits well above that
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 32;
  localparam int unsigned RANDOM_ITEMS = 525;
  localparam int unsigned CALM_ITEMS   = 100;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]        s_axis_tuser  = OP_APPEND;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [ST_W-1:0]        m_axis_tuser;

  list_mirror        mirror = new();
  bit                calm   = 1'b0;    // no idling on either side once set
  int unsigned       steady_items = 0; // requests still to go without a sender gap
  int unsigned       quiet_cycles = 0;
  logic [ELEM_W-1:0] pool [8];         // small set of words so searches hit often

  list_append_search_remove DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // value, position, zero pad
    .s_axis_tuser  (s_axis_tuser),  // operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // found_index, element, count, zero pad
    .m_axis_tuser  (m_axis_tuser)   // status
  );

  initial forever #1 clk_i = ~clk_i;

  // present one request beat, hold it until accepted, then maybe leave a gap
  task automatic send(op_e op, logic [ELEM_W-1:0] v, logic [IDX_W-1:0] pos);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{IN_PAD_W{1'b0}}, pos, v};
    do @(posedge clk_i); while (!s_axis_tready);
    mirror.note_request(op, v, pos);
    if (steady_items > 0) begin
      steady_items--;
    end else if (!calm && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end else if ($urandom_range(0, 15) == 0) begin
      steady_items = $urandom_range(20, 60);
    end
  endtask

  // result side: mostly ready, with short stalls and now and then a long clean run
  initial begin
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(50, 200)) @(posedge clk_i);
      else repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (!calm) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
  end

  // every result beat is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      mirror.check_result(m_axis_tuser, m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W +: ELEM_W],
                          m_axis_tdata[IDX_W+ELEM_W +: CNT_W]);
  end

  // watchdog: too long without a beat on either side means the block hung
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("list_append_search_remove_test failed");
      $finish;
    end
  end

  initial begin
    int unsigned       k;
    int unsigned       cnt_now;
    int unsigned       pick;
    op_e               op;
    logic [ELEM_W-1:0] v;
    logic [IDX_W-1:0]  pos;

    pool[0] = '0;
    pool[1] = '1;
    for (k = 2; k < 8; k++) pool[k] = $urandom;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: every lookup misses
    send(OP_READ,   32'h0000_0000, 10'd0);
    send(OP_FIND,   32'hffff_ffff, 10'd0);
    send(OP_REMOVE, 32'h0000_0000, 10'd0);
    // small list with a duplicate word
    send(OP_APPEND, 32'h0000_0000, 10'd1023);
    send(OP_APPEND, 32'hffff_ffff, 10'd0);
    send(OP_APPEND, 32'ha5a5_a5a5, 10'd0);
    send(OP_APPEND, 32'hffff_ffff, 10'd0);
    send(OP_APPEND, 32'h5a5a_5a5a, 10'd0);
    send(OP_READ,   32'h0000_0000, 10'd0);
    send(OP_READ,   32'h0000_0000, 10'd1);
    send(OP_READ,   32'hffff_ffff, 10'd4);
    send(OP_READ,   32'h0000_0000, 10'd5);     // index equal to the count
    send(OP_READ,   32'h0000_0000, 10'd1023);
    send(OP_FIND,   32'hffff_ffff, 10'd0);
    send(OP_FIND,   32'hffff_ffff, 10'd2);     // skips the first copy
    send(OP_FIND,   32'hffff_ffff, 10'd4);
    send(OP_FIND,   32'h0000_0000, 10'd5);     // start equal to the count
    send(OP_FIND,   32'h5a5a_5a5a, 10'd1023);
    send(OP_REMOVE, 32'hffff_ffff, 10'd2);     // second copy goes, tail shifts down
    send(OP_READ,   32'h0000_0000, 10'd3);
    send(OP_REMOVE, 32'h0000_0000, 10'd0);     // head entry
    send(OP_REMOVE, 32'h5a5a_5a5a, 10'd0);     // tail entry
    send(OP_REMOVE, 32'h1234_5678, 10'd0);
    send(OP_READ,   32'h0000_0000, 10'd0);

    // random mix on a short list, the last stretch without idling
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      cnt_now = mirror.cnt;
      pick    = $urandom_range(0, 99);
      if (cnt_now < 6)       op = (pick < 55) ? OP_APPEND : op_e'(pick % 4);
      else if (cnt_now > 48) op = (pick < 40) ? OP_REMOVE : op_e'(pick % 4);
      else                   op = op_e'(pick % 4);
      v = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 7)] : $urandom;
      if ($urandom_range(0, 6) == 0)      pos = IDX_W'($urandom_range(0, 1023));
      else if ($urandom_range(0, 1) == 0) pos = '0;
      else                                pos = IDX_W'($urandom_range(0, cnt_now + 1));
      send(op, v, pos);
    end
    s_axis_tvalid <= 1'b0;

    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("list_append_search_remove_test passed");
    end else begin
      $display("list_append_search_remove_test failed");
    end
    $finish;
  end

endmodule
